// File: src/matrix_multiply_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply engine
// Shorthands for clocked concurrent checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// Same-cycle implication
`define MME_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define MME_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// File: src/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared widths, opcodes, register indexes and state codes of the matrix
// multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

   // Default largest matrix dimension
   localparam int MAX_DIM_DEFAULT = 8;

   // Field widths
   localparam int DATA_W = 32;
   localparam int IDX_W  = 3;
   localparam int DIM_W  = 4;
   localparam int OP_W   = 2;
   localparam int CSR_W  = 2;

   // Opcodes of a request transaction
   localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
   localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_W-1:0] CSR_ROWS_A = 2'd0;
   localparam logic [CSR_W-1:0] CSR_COLS_A = 2'd1;
   localparam logic [CSR_W-1:0] CSR_ROWS_B = 2'd2;
   localparam logic [CSR_W-1:0] CSR_COLS_B = 2'd3;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MAC   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   // Clamp a dimension register to 1..max_dim
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] max_dim);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > max_dim) begin
         r = max_dim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: src/mme_ram.sv
// ----------------------------------------------------------------------------
// mme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/matrix_multiply_engine.sv
// Load transactions (A or B element) produce no response.
// A run computes the rows_a * cols_b entries in turn: one multiply-accumulate
// per cycle through the shared multiplier, a drain of the RAM read and product
// registers, then a hand-over to the output register, held by response stalls.
// A dimension mismatch answers the run with one registered error response.
// Synchronous active-high reset: sequencer idle, no response, dimensions 1.
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Integer matrix multiply C = A * B over two element RAMs, using a single
// multiply-accumulate unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
`include "matrix_multiply_engine_assert.svh"

module matrix_multiply_engine #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mme_pkg::OP_W-1:0]    req_op,
   input  logic [mme_pkg::IDX_W-1:0]   req_row,
   input  logic [mme_pkg::IDX_W-1:0]   req_col,
   input  logic signed [mme_pkg::DATA_W-1:0] req_value,
   // Response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mme_pkg::IDX_W-1:0]   rsp_row_res,
   output logic [mme_pkg::IDX_W-1:0]   rsp_col_res,
   output logic signed [mme_pkg::DATA_W-1:0] rsp_value_res,
   output logic                        rsp_last,
   output logic                        rsp_error,
   // Configuration write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [mme_pkg::CSR_W-1:0]   csr_index,
   input  logic [mme_pkg::DIM_W-1:0]   csr_data
);

   import mme_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

   // Dimension registers
   logic [DIM_W-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;

   // Sequencer
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [IDX_W-1:0] last_r_ff, last_r_in, last_c_ff, last_c_in, last_k_ff, last_k_in;

   // MAC pipeline
   logic              d_valid_ff, d_last_ff;
   logic              m_valid_ff, m_last_ff;
   logic [DATA_W-1:0] prod_ff;
   logic [DATA_W-1:0] acc_ff, acc_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in, rsp_error_ff, rsp_error_in;

   // RAM ports
   logic              wr_a_en, wr_b_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0] rd_data_a, rd_data_b;

   logic req_accept, idx_in_range, dims_match, out_free, entry_last;
   logic [DIM_W-1:0] eff_ra, eff_ca, eff_rb, eff_cb;

   // Handshakes
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && (req_op == OP_RUN));
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= DIM_W'(1);
         cols_a_ff <= DIM_W'(1);
         rows_b_ff <= DIM_W'(1);
         cols_b_ff <= DIM_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROWS_A: rows_a_ff <= csr_data;
            CSR_COLS_A: cols_a_ff <= csr_data;
            CSR_ROWS_B: rows_b_ff <= csr_data;
            CSR_COLS_B: cols_b_ff <= csr_data;
            default:    rows_a_ff <= rows_a_ff;
         endcase
      end
   end

   // Effective dimensions
   assign eff_ra     = eff_dim(rows_a_ff, MAX_DIM_V);
   assign eff_ca     = eff_dim(cols_a_ff, MAX_DIM_V);
   assign eff_rb     = eff_dim(rows_b_ff, MAX_DIM_V);
   assign eff_cb     = eff_dim(cols_b_ff, MAX_DIM_V);
   assign dims_match = (eff_ca == eff_rb);

   // Element loads
   assign idx_in_range = (32'(req_row) < MAX_DIM) && (32'(req_col) < MAX_DIM);
   assign wr_addr = ADDR_W'(32'(req_row) * MAX_DIM + 32'(req_col));
   assign wr_a_en = req_accept && (req_op == OP_LOAD_A) && idx_in_range;
   assign wr_b_en = req_accept && (req_op == OP_LOAD_B) && idx_in_range;

   // Read addresses: A[r][k] and B[k][c]
   assign rd_addr_a = ADDR_W'(32'(r_ff) * MAX_DIM + 32'(k_ff));
   assign rd_addr_b = ADDR_W'(32'(k_ff) * MAX_DIM + 32'(c_ff));

   mme_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   mme_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   // Read and multiply stages; low 32 bits are all the sum needs
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= (state_ff == ST_MAC);
         m_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_last_ff <= (k_ff == last_k_ff);
      m_last_ff <= d_last_ff;
      prod_ff   <= rd_data_a * rd_data_b;
   end

   assign entry_last = (r_ff == last_r_ff) && (c_ff == last_c_ff);

   // Sequencer and accumulator
   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      last_r_in    = last_r_ff;
      last_c_in    = last_c_ff;
      last_k_in    = last_k_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;

      if (m_valid_ff) begin
         acc_in = acc_ff + prod_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_op == OP_RUN)) begin
               if (dims_match) begin
                  r_in      = '0;
                  c_in      = '0;
                  k_in      = '0;
                  acc_in    = '0;
                  last_r_in = IDX_W'(eff_ra - DIM_W'(1));
                  last_c_in = IDX_W'(eff_cb - DIM_W'(1));
                  last_k_in = IDX_W'(eff_ca - DIM_W'(1));
                  state_in  = ST_MAC;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = '0;
                  rsp_col_in   = '0;
                  rsp_value_in = '0;
                  rsp_last_in  = 1'b1;
                  rsp_error_in = 1'b1;
               end
            end
         end
         ST_MAC: begin
            if (k_ff == last_k_ff) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (m_valid_ff && m_last_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = r_ff;
               rsp_col_in   = c_ff;
               rsp_value_in = acc_ff;
               rsp_last_in  = entry_last;
               rsp_error_in = 1'b0;
               k_in         = '0;
               acc_in       = '0;
               if (entry_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MAC;
                  if (c_ff == last_c_ff) begin
                     c_in = '0;
                     r_in = r_ff + IDX_W'(1);
                  end else begin
                     c_in = c_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff         <= r_in;
      c_ff         <= c_in;
      k_ff         <= k_in;
      last_r_ff    <= last_r_in;
      last_c_ff    <= last_c_in;
      last_k_ff    <= last_k_in;
      acc_ff       <= acc_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   // Response outputs
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_res   = rsp_row_ff;
   assign rsp_col_res   = rsp_col_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_error     = rsp_error_ff;

   // Checks
   `MME_ASSERT_NEXT(a_run_starts, clock, reset, req_accept && (req_op == OP_RUN) && dims_match, state_ff == ST_MAC, "matched run did not start MAC")
   `MME_ASSERT_NOW(a_mac_in_run, clock, reset, m_valid_ff, (state_ff == ST_MAC) || (state_ff == ST_DRAIN), "product outside of a run")
   `MME_ASSERT_NEXT(a_drain_done, clock, reset, (state_ff == ST_DRAIN) && m_valid_ff && m_last_ff, state_ff == ST_OUT, "drain did not reach output")
   `MME_ASSERT_NOW(a_error_last, clock, reset, rsp_valid_ff && rsp_error_ff, rsp_last_ff, "error transaction not marked last")

endmodule
